// File: rtl/utf7d_pkg.sv
// Shared types, character constants and the base64 lookup for the UTF-7 stream decoder.
package utf7d_pkg;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] BYTE_MASK = 8'hFF;

    localparam logic OP_DATA     = 1'b0;
    localparam logic OP_LINE_END = 1'b1;

    localparam int BUF_W  = 21;
    localparam int CNT_W  = 5;
    localparam int UNIT_W = 16;

    typedef enum logic [2:0] {
        MODE_DIRECT  = 3'b001,
        MODE_SHIFTED = 3'b010,
        MODE_PLUS    = 3'b100
    } mode_t;

    typedef struct packed {
        mode_t              mode;
        logic [BUF_W-1:0]   bits;
        logic [CNT_W-1:0]   count;
    } dec_state_t;

    typedef struct packed {
        logic              emit;
        logic [UNIT_W-1:0] unit;
    } step_out_t;

    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } b64_t;

    // Maps a byte to its 6-bit base64 value; ok is low for any other byte.
    function automatic b64_t b64_decode(input logic [7:0] c);
        b64_t r;
        r.ok  = 1'b1;
        r.val = 6'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r.val = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r.val = 6'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r.val = 6'(c - 8'h30 + 8'd52);
        end else if (c == CH_PLUS) begin
            r.val = 6'd62;
        end else if (c == CH_SLASH) begin
            r.val = 6'd63;
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

// File: rtl/utf7_stream_decoder.sv
// Top level of the UTF-7 stream decoder: input register, decode state and result register.
// Path: a byte accepted into the input register is decoded and its code unit is loaded into
// the result register that drives m_code_unit, unless the result side is stalled.
// Throughput: one byte per cycle; the combinational decode between the input register and the
// result register sets that rate, and both registers advance whenever the result is free.
// Reset: synchronous, active-low aresetn empties both registers and returns the decoder to
// direct mode with an empty bit buffer.
module utf7_stream_decoder
    import utf7d_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_code_unit
);

    // Input register. It holds one accepted transaction until the decode stage takes it.
    logic       in_valid_reg;
    logic       in_op_reg;
    logic [7:0] in_byte_reg;

    // Decoder state: mode, pending base64 bits and their count.
    dec_state_t state_reg;
    dec_state_t state_next;

    // Result register toward the m_ channel.
    logic              out_valid_reg;
    logic [UNIT_W-1:0] out_unit_reg;

    step_out_t step_res;
    logic      advance;
    logic      fire;

    // The decode stage moves forward whenever the result register is empty or being drained,
    // so a pending result never blocks a new byte unless the consumer actually stalls.
    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    utf7d_step u_step (
        .cur       (state_reg),
        .operation (in_op_reg),
        .data_byte (in_byte_reg),
        .nxt       (state_next),
        .res       (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // Payload of the input register needs no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg   <= s_operation;
            in_byte_reg <= s_data_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode  <= MODE_DIRECT;
            state_reg.bits  <= '0;
            state_reg.count <= '0;
        end else if (fire) begin
            state_reg <= state_next;
        end
    end

    // A transaction that produces no code unit (line end, '+', '-' terminator, partial bits)
    // simply leaves the result register empty.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= fire && step_res.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && step_res.emit) begin
            out_unit_reg <= step_res.unit;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_code_unit = out_unit_reg;

    // Between transactions the buffer never holds a whole code unit.
    a_count_below_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.count < CNT_W'(UNIT_W))
        else $error("bit count reached a full code unit without emitting it");

    a_mode_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg.mode))
        else $error("decode mode lost its one-hot code");

    a_line_end_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_op_reg == OP_LINE_END |=>
            state_reg.mode == MODE_DIRECT && state_reg.count == '0 && !out_valid_reg)
        else $error("line end did not flush the decoder");

    a_held_byte_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
        else $error("stalled input byte was lost");

endmodule

// File: rtl/utf7d_step.sv
// Next-state and result logic for one decoded byte of the UTF-7 stream decoder.
module utf7d_step
    import utf7d_pkg::*;
(
    input  dec_state_t cur,
    input  logic       operation,
    input  logic [7:0] data_byte,
    output dec_state_t nxt,
    output step_out_t  res
);

    b64_t             b64;
    logic             from_plus;
    logic [BUF_W-1:0] base_bits;
    logic [CNT_W-1:0] base_cnt;
    logic [BUF_W-1:0] sum_bits;
    logic [CNT_W-1:0] sum_cnt;
    logic [CNT_W-1:0] sh;
    logic [BUF_W-1:0] keep_mask;
    logic [BUF_W-1:0] shifted_bits;
    logic             full;

    assign b64       = b64_decode(data_byte);
    assign from_plus = (cur.mode == MODE_PLUS);

    // A base64 character right after '+' starts from an empty buffer.
    assign base_bits = from_plus ? '0 : cur.bits;
    assign base_cnt  = from_plus ? '0 : cur.count;

    assign sum_bits     = {base_bits[BUF_W-7:0], b64.val};
    assign sum_cnt      = base_cnt + CNT_W'(6);
    assign full         = (sum_cnt >= CNT_W'(UNIT_W));
    assign sh           = sum_cnt - CNT_W'(UNIT_W);
    assign shifted_bits = sum_bits >> sh;
    assign keep_mask    = (BUF_W'(1) << sh) - BUF_W'(1);

    always_comb begin
        nxt      = cur;
        res.emit = 1'b0;
        res.unit = {8'h00, data_byte & BYTE_MASK};
        if (operation == OP_LINE_END) begin
            nxt.mode  = MODE_DIRECT;
            nxt.bits  = '0;
            nxt.count = '0;
        end else begin
            case (cur.mode)
                MODE_SHIFTED, MODE_PLUS: begin
                    if (from_plus && data_byte == CH_MINUS) begin
                        nxt.mode = MODE_DIRECT;
                        res.emit = 1'b1;
                        res.unit = {8'h00, CH_PLUS};
                    end else if (b64.ok) begin
                        nxt.mode = MODE_SHIFTED;
                        if (full) begin
                            res.emit  = 1'b1;
                            res.unit  = shifted_bits[UNIT_W-1:0];
                            nxt.bits  = sum_bits & keep_mask;
                            nxt.count = sh;
                        end else begin
                            nxt.bits  = sum_bits;
                            nxt.count = sum_cnt;
                        end
                    end else begin
                        nxt.mode  = MODE_DIRECT;
                        nxt.bits  = '0;
                        nxt.count = '0;
                        // A closing '-' is absorbed; other terminators pass through.
                        res.emit  = from_plus || (data_byte != CH_MINUS);
                    end
                end
                default: begin
                    if (data_byte == CH_PLUS) begin
                        nxt.mode = MODE_PLUS;
                    end else begin
                        nxt.mode = MODE_DIRECT;
                        res.emit = 1'b1;
                    end
                end
            endcase
        end
    end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the UTF-7 stream decoder: directed cases, then random traffic.
module tb
    import utf7d_pkg::*;
();

    // The run ends well before this bound even with heavy stalls on both sides, so this bound
    // only trips when the handshake hangs.
    localparam int CYCLE_LIMIT  = 200000;
    // The decoder passes each byte through its input register and its result register. The
    // DRAIN_CYCLES idle cycles at the end give a spurious late result time to show up.
    localparam int DRAIN_CYCLES = 8;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_operation = OP_DATA;
    logic [7:0]  s_data_byte = 8'h00;
    logic        m_ready     = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [15:0] m_code_unit;

    // Chance, in percent, that a side holds off in a given cycle.
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int mismatch_count = 0;
    int items_sent     = 0;
    int cycle_count    = 0;

    // Base64 alphabet in index order. The lookup table built from it gives the 6-bit value
    // of a byte, or -1 for a byte that is not part of the alphabet.
    string b64_alphabet =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    int    b64_lut[256];

    // Our own copy of the decoder state. It is advanced once per accepted transaction on the
    // input side, in the same order as the hardware sees the bytes.
    mode_t             dec_mode  = MODE_DIRECT;
    logic [BUF_W-1:0]  dec_bits  = '0;
    logic [CNT_W-1:0]  dec_count = '0;

    // Code units that the decoder still owes us, oldest first.
    logic [15:0] expected_units[$];

    utf7_stream_decoder dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_data_byte (s_data_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_code_unit (m_code_unit)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        foreach (b64_lut[i]) b64_lut[i] = -1;
        for (int i = 0; i < 64; i++) b64_lut[b64_alphabet[i]] = i;
    end

    // Appends six bits to the pending buffer. Once sixteen or more bits are held, the oldest
    // sixteen leave as one code unit and only the remainder stays in the buffer.
    function automatic bit shift_in_bits(input int value, output logic [15:0] unit);
        int sh;
        unit      = '0;
        dec_bits  = {dec_bits[BUF_W-7:0], 6'(value)};
        dec_count = dec_count + 5'd6;
        if (dec_count >= 5'd16) begin
            sh        = int'(dec_count) - 16;
            unit      = 16'(dec_bits >> sh);
            dec_count = CNT_W'(sh);
            dec_bits  = dec_bits & ((BUF_W'(1) << sh) - BUF_W'(1));
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advances the expected decoder state by one input byte or line end. Returns 1 when the
    // transaction produces a code unit, which is then placed in unit.
    function automatic bit decode_expected(input logic op, input logic [7:0] c,
                                           output logic [15:0] unit);
        int value;
        value = b64_lut[c];
        unit  = '0;
        // A line end throws away whatever bits are left and goes back to plain bytes.
        if (op == OP_LINE_END) begin
            dec_mode  = MODE_DIRECT;
            dec_bits  = '0;
            dec_count = '0;
            return 1'b0;
        end
        case (dec_mode)
            MODE_SHIFTED: begin
                if (value >= 0) begin
                    return shift_in_bits(value, unit);
                end
                // Any byte outside the alphabet closes the sequence and drops leftover bits.
                // A dash is swallowed; anything else passes through as a plain character.
                dec_mode  = MODE_DIRECT;
                dec_bits  = '0;
                dec_count = '0;
                if (c == CH_MINUS) begin
                    return 1'b0;
                end
                unit = {8'h00, c};
                return 1'b1;
            end
            MODE_PLUS: begin
                // A dash right after the plus sign is the escape for a literal plus.
                if (c == CH_MINUS) begin
                    dec_mode = MODE_DIRECT;
                    unit     = {8'h00, CH_PLUS};
                    return 1'b1;
                end
                dec_bits  = '0;
                dec_count = '0;
                if (value >= 0) begin
                    dec_mode = MODE_SHIFTED;
                    return shift_in_bits(value, unit);
                end
                dec_mode = MODE_DIRECT;
                unit     = {8'h00, c};
                return 1'b1;
            end
            default: begin
                if (c == CH_PLUS) begin
                    dec_mode = MODE_PLUS;
                    return 1'b0;
                end
                dec_mode = MODE_DIRECT;
                unit     = {8'h00, c};
                return 1'b1;
            end
        endcase
    endfunction

    // Input and output monitor. A transaction on the input side updates the expected state
    // and may queue a code unit. A transaction on the result side is compared against the
    // oldest queued code unit. The prediction runs first, so even a decoder with no latency
    // would be checked correctly.
    always @(posedge aclk) begin : scoreboard
        logic [15:0] unit;
        logic [15:0] want;
        if (aresetn && s_valid && s_ready) begin
            if (decode_expected(s_operation, s_data_byte, unit)) begin
                expected_units = {expected_units, unit};
            end
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_units.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected code_unit, expected none, actual %h",
                         $time, m_code_unit);
            end else begin
                want = expected_units.pop_front();
                if (m_code_unit !== want) begin
                    mismatch_count++;
                    $display("%0t: code_unit mismatch, expected %h, actual %h",
                             $time, want, m_code_unit);
                end
            end
        end
    end

    // The receiver holds off at random, in proportion to the current phase setting.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: cycle limit reached with %0d code units outstanding",
                     $time, expected_units.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Sends one transaction. It is called at a rising edge and returns at the edge where the
    // decoder takes the item. Idle cycles come before valid is raised; once raised, valid and
    // the payload stay put until the transaction completes.
    task automatic send_item(input logic op, input logic [7:0] byte_value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_data_byte <= byte_value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++) send_item(OP_DATA, text[i]);
    endtask

    // Stops the sender until every predicted code unit has come out of the decoder.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_units.size() != 0);
    endtask

    // Any byte other than a plus sign, so the decoder stays in plain mode.
    function automatic logic [7:0] random_plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (b == CH_PLUS);
        return b;
    endfunction

    // Any byte outside the base64 alphabet; a dash is possible too.
    function automatic logic [7:0] random_terminator();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (b64_lut[b] >= 0);
        return b;
    endfunction

    // Short directed list: byte extremes in plain mode, the escaped plus, every way a
    // sequence can end, the first character after the plus sign, and line ends in each mode.
    task automatic test_directed_cases();
        send_item(OP_DATA, 8'h00);
        send_item(OP_DATA, 8'hFF);
        send_item(OP_DATA, 8'h80);
        send_text("A-");
        // A line end in plain mode; its data byte must be ignored.
        send_item(OP_LINE_END, 8'hFF);
        send_text("+-");
        // Plus followed by a byte outside the alphabet gives that byte back.
        send_text("+!");
        // "AGE" carries 0x0061; the closing dash is swallowed.
        send_text("+AGE-");
        // A plus sign as the first base64 character, slashes, then a period that both
        // closes the sequence and comes out as a plain character.
        send_text("++//.");
        // A line end with bits still pending in the buffer.
        send_text("+z");
        send_item(OP_LINE_END, 8'h00);
        // A line end right after the plus sign.
        send_item(OP_DATA, CH_PLUS);
        send_item(OP_LINE_END, 8'h2D);
    endtask

    // Mostly well-formed shifted sequences with random content and length, surrounded by
    // plain text and closed by a dash, another byte, a line end, or nothing at all.
    task automatic test_shifted_sequences(input int n_items);
        int stop_at;
        int len;
        int kind;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            repeat ($urandom_range(0, 3)) send_item(OP_DATA, random_plain_byte());
            if ($urandom_range(99) < 8) begin
                send_text("+-");
            end else begin
                send_item(OP_DATA, CH_PLUS);
                len = ($urandom_range(99) < 10) ? $urandom_range(13, 24) : $urandom_range(1, 12);
                repeat (len) send_item(OP_DATA, b64_alphabet[$urandom_range(63)]);
                kind = $urandom_range(99);
                if (kind < 50) begin
                    send_item(OP_DATA, CH_MINUS);
                end else if (kind < 75) begin
                    send_item(OP_DATA, random_terminator());
                end else if (kind < 90) begin
                    send_item(OP_LINE_END, 8'($urandom_range(255)));
                end
            end
        end
    endtask

    // Unstructured noise, weighted toward plus signs, dashes and line ends.
    task automatic test_random_bytes(input int n_items);
        int pick;
        repeat (n_items) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                send_item(OP_LINE_END, 8'($urandom_range(255)));
            end else if (pick < 20) begin
                send_item(OP_DATA, CH_PLUS);
            end else if (pick < 28) begin
                send_item(OP_DATA, CH_MINUS);
            end else begin
                send_item(OP_DATA, 8'($urandom_range(255)));
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 23;
        recv_idle_pct = 51;
        test_directed_cases();

        // Three phases of random traffic: a slow receiver, then a slow sender, then both
        // at full rate. Between phases the sender waits for the decoder to drain.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 23;
                    recv_idle_pct = 51;
                end
                1: begin
                    send_idle_pct = 51;
                    recv_idle_pct = 23;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            test_shifted_sequences(420);
            test_random_bytes(110);
            wait_for_results();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_units.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
